// ===== design/gather_copy_command_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gather copy command generator
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef GATHER_COPY_COMMAND_GENERATOR_ASSERT_SVH
`define GATHER_COPY_COMMAND_GENERATOR_ASSERT_SVH

// same-cycle implication
`define GCCG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GCCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/gccg_pkg.sv =====
// ----------------------------------------------------------------------------
// gccg_pkg
// Shared types and constants of the gather copy command generator.
// ----------------------------------------------------------------------------
package gccg_pkg;

	localparam int AXIS_W   = 31;
	localparam int SPEC_W   = 32;
	localparam int CNT_W    = 7;
	localparam int BYTES_W  = 32;
	localparam int STRIDE_W = 40;
	localparam int FIELD_W  = 40;
	localparam int INDEX_W  = 32;
	localparam int MUL_W    = 32;
	localparam int CFG_AW   = 4;
	localparam int CFG_DW   = 40;

	typedef enum logic [CFG_AW-1:0] {
		REG_AXIS_DIM         = 4'd0,
		REG_SPEC_COUNT       = 4'd1,
		REG_OUTER_COUNT      = 4'd2,
		REG_SLICE_BYTES      = 4'd3,
		REG_SRC_BATCH_STRIDE = 4'd4,
		REG_SRC_OUTER_STRIDE = 4'd5,
		REG_DST_OUTER_STRIDE = 4'd6,
		REG_DST_BATCH_STRIDE = 4'd7
	} reg_index_t;

	typedef struct packed {
		logic [AXIS_W-1:0]   axis_dim;
		logic [SPEC_W-1:0]   spec_count;
		logic [CNT_W-1:0]    outer_count;
		logic [BYTES_W-1:0]  slice_bytes;
		logic [STRIDE_W-1:0] src_batch_stride;
		logic [STRIDE_W-1:0] src_outer_stride;
		logic [STRIDE_W-1:0] dst_outer_stride;
		logic [STRIDE_W-1:0] dst_batch_stride;
	} cfg_t;

	typedef struct packed {
		logic             fill;
		logic [CNT_W-1:0] count;
	} cmd_ctl_t;

	typedef struct packed {
		logic [FIELD_W-1:0] src_offset;
		logic [FIELD_W-1:0] dst_offset;
		logic [BYTES_W-1:0] byte_count;
		logic               zero_fill;
		logic               last;
	} res_t;

endpackage

// ===== design/gather_copy_command_generator.sv =====
// ----------------------------------------------------------------------------
// gather_copy_command_generator
// Path: front multiply and sum states, command queue, back walker, result queue.
// The front takes no index while its three-pass base-offset multiply sequencer
// runs; the back gives one command a beat unless the result queue is full.
// Reset: asynchronous, clears counters and queues, registers take reset values.
// ----------------------------------------------------------------------------
module gather_copy_command_generator #(
	parameter int MAX_OUTER    = 64,
	parameter int OFFSET_WIDTH = 40
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [gccg_pkg::CFG_AW-1:0]          cfg_index,
	input  logic [gccg_pkg::CFG_DW-1:0]          cfg_data,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [gccg_pkg::INDEX_W-1:0]  gather_index,
	input  logic                                 job_start,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [gccg_pkg::FIELD_W-1:0]         src_offset,
	output logic [gccg_pkg::FIELD_W-1:0]         dst_offset,
	output logic [gccg_pkg::BYTES_W-1:0]         byte_count,
	output logic                                 zero_fill,
	output logic                                 last
);

	`include "gather_copy_command_generator_assert.svh"

	localparam int CMD_W = 2 * OFFSET_WIDTH + $bits(gccg_pkg::cmd_ctl_t);
	localparam int RES_W = $bits(gccg_pkg::res_t);

	gccg_pkg::cfg_t          cfg_q;

	logic                    cmd_valid;
	logic                    cmd_full;
	logic                    cmd_empty;
	logic                    cmd_pop;
	logic [OFFSET_WIDTH-1:0] front_src_base;
	logic [OFFSET_WIDTH-1:0] front_dst_base;
	gccg_pkg::cmd_ctl_t      front_ctl;
	logic [OFFSET_WIDTH-1:0] back_src_base;
	logic [OFFSET_WIDTH-1:0] back_dst_base;
	gccg_pkg::cmd_ctl_t      back_ctl;
	logic [CMD_W-1:0]        cmd_wdata;
	logic [CMD_W-1:0]        cmd_rdata;

	logic                    res_push;
	logic                    res_full;
	gccg_pkg::res_t          res_in;
	gccg_pkg::res_t          res_out;
	logic [RES_W-1:0]        res_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_dim         <= gccg_pkg::AXIS_W'(1);
			cfg_q.spec_count       <= gccg_pkg::SPEC_W'(1);
			cfg_q.outer_count      <= gccg_pkg::CNT_W'(1);
			cfg_q.slice_bytes      <= gccg_pkg::BYTES_W'(1);
			cfg_q.src_batch_stride <= '0;
			cfg_q.src_outer_stride <= '0;
			cfg_q.dst_outer_stride <= '0;
			cfg_q.dst_batch_stride <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				gccg_pkg::REG_AXIS_DIM:
					cfg_q.axis_dim <= cfg_data[gccg_pkg::AXIS_W-1:0];
				gccg_pkg::REG_SPEC_COUNT:
					cfg_q.spec_count <= cfg_data[gccg_pkg::SPEC_W-1:0];
				gccg_pkg::REG_OUTER_COUNT:
					cfg_q.outer_count <= cfg_data[gccg_pkg::CNT_W-1:0];
				gccg_pkg::REG_SLICE_BYTES:
					cfg_q.slice_bytes <= cfg_data[gccg_pkg::BYTES_W-1:0];
				gccg_pkg::REG_SRC_BATCH_STRIDE:
					cfg_q.src_batch_stride <= cfg_data[gccg_pkg::STRIDE_W-1:0];
				gccg_pkg::REG_SRC_OUTER_STRIDE:
					cfg_q.src_outer_stride <= cfg_data[gccg_pkg::STRIDE_W-1:0];
				gccg_pkg::REG_DST_OUTER_STRIDE:
					cfg_q.dst_outer_stride <= cfg_data[gccg_pkg::STRIDE_W-1:0];
				gccg_pkg::REG_DST_BATCH_STRIDE:
					cfg_q.dst_batch_stride <= cfg_data[gccg_pkg::STRIDE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gccg_front #(
		.MAX_OUTER    (MAX_OUTER),
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.full         (full),
		.gather_index (gather_index),
		.job_start    (job_start),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (!cmd_full),
		.cmd_src_base (front_src_base),
		.cmd_dst_base (front_dst_base),
		.cmd_ctl      (front_ctl)
	);

	assign cmd_wdata = {front_src_base, front_dst_base, front_ctl};
	assign {back_src_base, back_dst_base, back_ctl} = cmd_rdata;

	gccg_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_valid),
		.full   (cmd_full),
		.wdata  (cmd_wdata),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.rdata  (cmd_rdata)
	);

	gccg_back #(
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd_empty    (cmd_empty),
		.cmd_pop      (cmd_pop),
		.cmd_src_base (back_src_base),
		.cmd_dst_base (back_dst_base),
		.cmd_ctl      (back_ctl),
		.res_full     (res_full),
		.res_push     (res_push),
		.res          (res_in)
	);

	gccg_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_in),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_rdata)
	);

	assign res_out    = gccg_pkg::res_t'(res_rdata);
	assign src_offset = res_out.src_offset;
	assign dst_offset = res_out.dst_offset;
	assign byte_count = res_out.byte_count;
	assign zero_fill  = res_out.zero_fill;
	assign last       = res_out.last;

	`GCCG_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, push && !full, full, "front took a second index during base calculation")
	`GCCG_ASSERT_SAME(a_cmd_no_overflow, clk, arst_n, cmd_valid && cmd_full, !cmd_pop || !cmd_empty, "command queue overflow")
	`GCCG_ASSERT_SAME(a_res_no_overflow, clk, arst_n, res_push, !res_full, "result queue overflow")
	`GCCG_ASSERT_SAME(a_fill_src_zero, clk, arst_n, !empty && zero_fill, src_offset == '0, "zero fill with nonzero source offset")

endmodule

// ===== design/gccg_fifo.sv =====
// ----------------------------------------------------------------------------
// gccg_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module gccg_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/gccg_front.sv =====
// ----------------------------------------------------------------------------
// gccg_front
// Accepts gather indices, wraps and range-checks them, keeps the batch and
// position counters and forms the source and destination base offsets with
// two shared 32x32 multipliers over three passes.
// ----------------------------------------------------------------------------
module gccg_front #(
	parameter int MAX_OUTER    = 64,
	parameter int OFFSET_WIDTH = 40
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gccg_pkg::cfg_t                       cfg,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [gccg_pkg::INDEX_W-1:0]  gather_index,
	input  logic                                 job_start,
	output logic                                 cmd_valid,
	input  logic                                 cmd_ready,
	output logic [OFFSET_WIDTH-1:0]              cmd_src_base,
	output logic [OFFSET_WIDTH-1:0]              cmd_dst_base,
	output gccg_pkg::cmd_ctl_t                   cmd_ctl
);

	localparam int MW   = gccg_pkg::MUL_W;
	localparam int PW   = 2 * MW;
	localparam int WW   = PW + MW;
	localparam int IW   = gccg_pkg::INDEX_W;
	localparam int AXW  = gccg_pkg::AXIS_W;
	localparam int CW   = gccg_pkg::CNT_W;
	localparam int SW   = gccg_pkg::STRIDE_W;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL0,
		F_MUL1,
		F_MUL2,
		F_SUM,
		F_PUSH
	} fstate_t;

	fstate_t               state_q;
	logic [MW-1:0]         batch_q;
	logic [MW-1:0]         pos_q;
	logic [MW-1:0]         batch_s1;
	logic [MW-1:0]         pos_s1;
	logic [AXW-1:0]        idx_s1;
	logic                  fill_s1;
	logic [CW-1:0]         count_s1;
	logic [PW-1:0]         prod_src_s2;
	logic [PW-1:0]         prod_dst_s2;
	logic                  prod_hi_s2;
	logic [OFFSET_WIDTH-1:0] src_acc_q;
	logic [OFFSET_WIDTH-1:0] dst_acc_q;

	logic                  accept;
	logic [IW:0]           idx_ext;
	logic [IW:0]           idx_adj;
	logic                  fill;
	logic [CW-1:0]         count;
	logic [MW-1:0]         batch_eff;
	logic [MW-1:0]         pos_eff;
	logic [MW-1:0]         pos_next;
	logic [MW-1:0]         a_src;
	logic [MW-1:0]         b_src;
	logic [MW-1:0]         a_dst;
	logic [MW-1:0]         b_dst;
	logic                  op_hi;
	logic [WW-1:0]         src_wide;
	logic [WW-1:0]         dst_wide;

	assign full   = !(state_q == F_IDLE || (state_q == F_PUSH && cmd_ready));
	assign accept = push && !full;

	assign idx_ext = {gather_index[IW-1], gather_index};
	assign idx_adj = idx_ext + (gather_index[IW-1] ? (IW+1)'(cfg.axis_dim) : '0);
	assign fill    = idx_adj[IW] || (idx_adj[IW-1:0] >= IW'(cfg.axis_dim));

	always_comb begin
		if (cfg.outer_count == '0) begin
			count = CW'(1);
		end else if (cfg.outer_count > CW'(MAX_OUTER)) begin
			count = CW'(MAX_OUTER);
		end else begin
			count = cfg.outer_count;
		end
	end

	assign batch_eff = job_start ? '0 : batch_q;
	assign pos_eff   = job_start ? '0 : pos_q;
	assign pos_next  = pos_eff + 1'b1;

	always_comb begin
		a_src = cfg.src_batch_stride[MW-1:0];
		b_src = batch_s1;
		a_dst = cfg.dst_batch_stride[MW-1:0];
		b_dst = batch_s1;
		op_hi = 1'b0;
		case (state_q)
			F_MUL1: begin
				a_src = MW'(cfg.src_batch_stride[SW-1:MW]);
				a_dst = MW'(cfg.dst_batch_stride[SW-1:MW]);
				op_hi = 1'b1;
			end
			F_MUL2: begin
				a_src = cfg.slice_bytes;
				b_src = MW'(idx_s1);
				a_dst = cfg.slice_bytes;
				b_dst = pos_s1;
			end
			default: begin
			end
		endcase
	end

	assign src_wide = {{MW{1'b0}}, prod_src_s2} << (prod_hi_s2 ? MW : 0);
	assign dst_wide = {{MW{1'b0}}, prod_dst_s2} << (prod_hi_s2 ? MW : 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			batch_q     <= '0;
			pos_q       <= '0;
			batch_s1    <= '0;
			pos_s1      <= '0;
			idx_s1      <= '0;
			fill_s1     <= 1'b0;
			count_s1    <= '0;
			prod_src_s2 <= '0;
			prod_dst_s2 <= '0;
			prod_hi_s2  <= 1'b0;
			src_acc_q   <= '0;
			dst_acc_q   <= '0;
		end else begin
			if (state_q inside {F_MUL0, F_MUL1, F_MUL2}) begin
				prod_src_s2 <= PW'(a_src) * PW'(b_src);
				prod_dst_s2 <= PW'(a_dst) * PW'(b_dst);
				prod_hi_s2  <= op_hi;
			end
			if (state_q inside {F_MUL1, F_MUL2, F_SUM}) begin
				src_acc_q <= src_acc_q + src_wide[OFFSET_WIDTH-1:0];
				dst_acc_q <= dst_acc_q + dst_wide[OFFSET_WIDTH-1:0];
			end
			case (state_q)
				F_MUL0: state_q <= F_MUL1;
				F_MUL1: state_q <= F_MUL2;
				F_MUL2: state_q <= F_SUM;
				F_SUM:  state_q <= F_PUSH;
				F_PUSH: begin
					if (accept) begin
						state_q <= F_MUL0;
					end else if (cmd_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					if (accept) begin
						state_q <= F_MUL0;
					end else begin
						state_q <= F_IDLE;
					end
				end
			endcase
			if (accept) begin
				batch_s1  <= batch_eff;
				pos_s1    <= pos_eff;
				idx_s1    <= fill ? '0 : idx_adj[AXW-1:0];
				fill_s1   <= fill;
				count_s1  <= count;
				src_acc_q <= '0;
				dst_acc_q <= '0;
				if (pos_next == cfg.spec_count) begin
					pos_q   <= '0;
					batch_q <= batch_eff + 1'b1;
				end else begin
					pos_q   <= pos_next;
					batch_q <= batch_eff;
				end
			end
		end
	end

	assign cmd_valid     = (state_q == F_PUSH);
	assign cmd_src_base  = src_acc_q;
	assign cmd_dst_base  = dst_acc_q;
	assign cmd_ctl.fill  = fill_s1;
	assign cmd_ctl.count = count_s1;

endmodule

// ===== design/gccg_back.sv =====
// ----------------------------------------------------------------------------
// gccg_back
// Walks the outer slices of one queued index, stepping offsets by the outer
// strides; emits one copy or fill command a beat unless result queue is full.
// ----------------------------------------------------------------------------
module gccg_back #(
	parameter int OFFSET_WIDTH = 40
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gccg_pkg::cfg_t          cfg,
	input  logic                    cmd_empty,
	output logic                    cmd_pop,
	input  logic [OFFSET_WIDTH-1:0] cmd_src_base,
	input  logic [OFFSET_WIDTH-1:0] cmd_dst_base,
	input  gccg_pkg::cmd_ctl_t      cmd_ctl,
	input  logic                    res_full,
	output logic                    res_push,
	output gccg_pkg::res_t          res
);

	localparam int CW = gccg_pkg::CNT_W;
	localparam int FW = gccg_pkg::FIELD_W;
	localparam int SW = gccg_pkg::STRIDE_W;

	logic                    busy_q;
	logic [CW-1:0]           k_q;
	logic [CW-1:0]           n_q;
	logic                    fill_q;
	logic [OFFSET_WIDTH-1:0] src_q;
	logic [OFFSET_WIDTH-1:0] dst_q;

	logic                    is_last;
	logic                    load;
	logic [OFFSET_WIDTH+FW-1:0] src_ext;
	logic [OFFSET_WIDTH+FW-1:0] dst_ext;
	logic [OFFSET_WIDTH+SW-1:0] src_step;
	logic [OFFSET_WIDTH+SW-1:0] dst_step;

	assign is_last  = (k_q == n_q - 1'b1);
	assign res_push = busy_q && !res_full;
	assign load     = !cmd_empty && (!busy_q || (res_push && is_last));
	assign cmd_pop  = load;

	assign src_ext  = {{FW{1'b0}}, src_q};
	assign dst_ext  = {{FW{1'b0}}, dst_q};
	assign src_step = {{OFFSET_WIDTH{1'b0}}, cfg.src_outer_stride};
	assign dst_step = {{OFFSET_WIDTH{1'b0}}, cfg.dst_outer_stride};

	assign res.src_offset = fill_q ? '0 : src_ext[FW-1:0];
	assign res.dst_offset = dst_ext[FW-1:0];
	assign res.byte_count = cfg.slice_bytes;
	assign res.zero_fill  = fill_q;
	assign res.last       = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			n_q    <= '0;
			fill_q <= 1'b0;
			src_q  <= '0;
			dst_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			k_q    <= '0;
			n_q    <= cmd_ctl.count;
			fill_q <= cmd_ctl.fill;
			src_q  <= cmd_src_base;
			dst_q  <= cmd_dst_base;
		end else if (res_push) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				k_q   <= k_q + 1'b1;
				src_q <= src_q + src_step[OFFSET_WIDTH-1:0];
				dst_q <= dst_q + dst_step[OFFSET_WIDTH-1:0];
			end
		end
	end

endmodule

// ===== verif/tb_gather_copy_command_generator.sv =====
// ----------------------------------------------------------------------------
// tb_gather_copy_command_generator
// Drives signed gather indices over the push handshake in random bursts and
// pops copy commands with random stalls. A scoreboard works out every copy
// command for each accepted index from its own batch and position counters
// and register copies, and checks each popped command field by field.
// Register settings change between phases, once all commands have drained.
// ----------------------------------------------------------------------------
module tb_gather_copy_command_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import gccg_pkg::*;

	localparam int MAX_OUTER  = 64;
	localparam int NUM_REGS   = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_WAIT = 12;

	class copy_cmd_board;
		logic [AXIS_W-1:0]   axis_dim         = AXIS_W'(1);
		logic [SPEC_W-1:0]   spec_count       = SPEC_W'(1);
		logic [CNT_W-1:0]    outer_count      = CNT_W'(1);
		logic [BYTES_W-1:0]  slice_bytes      = BYTES_W'(1);
		logic [STRIDE_W-1:0] src_batch_stride = '0;
		logic [STRIDE_W-1:0] src_outer_stride = '0;
		logic [STRIDE_W-1:0] dst_outer_stride = '0;
		logic [STRIDE_W-1:0] dst_batch_stride = '0;
		logic [31:0]         batch_cnt        = '0;
		logic [31:0]         pos_cnt          = '0;
		res_t                pending_cmds[$];
		int                  failures         = 0;

		function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
			case (idx)
				REG_AXIS_DIM:         axis_dim = val[AXIS_W-1:0];
				REG_SPEC_COUNT:       spec_count = val[SPEC_W-1:0];
				REG_OUTER_COUNT:      outer_count = val[CNT_W-1:0];
				REG_SLICE_BYTES:      slice_bytes = val[BYTES_W-1:0];
				REG_SRC_BATCH_STRIDE: src_batch_stride = val[STRIDE_W-1:0];
				REG_SRC_OUTER_STRIDE: src_outer_stride = val[STRIDE_W-1:0];
				REG_DST_OUTER_STRIDE: dst_outer_stride = val[STRIDE_W-1:0];
				REG_DST_BATCH_STRIDE: dst_batch_stride = val[STRIDE_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_index(logic [INDEX_W-1:0] gi, logic js);
			longint      sidx;
			longint      ax;
			bit          fill;
			int          n;
			logic [63:0] src_base;
			logic [63:0] dst_base;
			logic [63:0] s;
			logic [63:0] d;
			logic [63:0] ii;
			logic [31:0] nxt;
			res_t        cmd;
			if (js) begin
				batch_cnt = '0;
				pos_cnt = '0;
			end
			sidx = longint'($signed(gi));
			ax = longint'(axis_dim);
			if (sidx < 0)
				sidx = sidx + ax;
			fill = !(sidx >= 0 && sidx < ax);
			n = int'(outer_count);
			if (n == 0)
				n = 1;
			else if (n > MAX_OUTER)
				n = MAX_OUTER;
			src_base = 64'(src_batch_stride) * 64'(batch_cnt);
			if (!fill)
				src_base = src_base + 64'(slice_bytes) * 64'(sidx);
			dst_base = 64'(dst_batch_stride) * 64'(batch_cnt)
				+ 64'(slice_bytes) * 64'(pos_cnt);
			for (int i = 0; i < n; i++) begin
				ii = 64'(i);
				s = fill ? 64'd0 : src_base + 64'(src_outer_stride) * ii;
				d = dst_base + 64'(dst_outer_stride) * ii;
				cmd.src_offset = s[FIELD_W-1:0];
				cmd.dst_offset = d[FIELD_W-1:0];
				cmd.byte_count = slice_bytes;
				cmd.zero_fill = fill;
				cmd.last = (i == n - 1);
				pending_cmds.push_back(cmd);
			end
			nxt = pos_cnt + 32'd1;
			if (nxt == spec_count) begin
				pos_cnt = '0;
				batch_cnt = batch_cnt + 32'd1;
			end else begin
				pos_cnt = nxt;
			end
		endfunction

		function void check_cmd(res_t got);
			res_t want;
			if (pending_cmds.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected command: src %h dst %h bytes %h fill %b last %b",
						got.src_offset, got.dst_offset, got.byte_count, got.zero_fill,
						got.last);
				return;
			end
			want = pending_cmds.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display({"mismatch exp/got: src %h/%h dst %h/%h bytes %h/%h ",
						"fill %b/%b last %b/%b"},
						want.src_offset, got.src_offset, want.dst_offset, got.dst_offset,
						want.byte_count, got.byte_count, want.zero_fill, got.zero_fill,
						want.last, got.last);
			end
		endfunction

		function int pending();
			return pending_cmds.size();
		endfunction
	endclass

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_write    = 1'b0;
	logic [CFG_AW-1:0]   cfg_index    = '0;
	logic [CFG_DW-1:0]   cfg_data     = '0;
	logic                push         = 1'b0;
	logic                full;
	logic [INDEX_W-1:0]  gather_index = '0;
	logic                job_start    = 1'b0;
	logic                empty;
	logic                pop          = 1'b0;
	logic [FIELD_W-1:0]  src_offset;
	logic [FIELD_W-1:0]  dst_offset;
	logic [BYTES_W-1:0]  byte_count;
	logic                zero_fill;
	logic                last;

	copy_cmd_board board = new();
	int                  burst_left  = 0;
	int                  idle_cycles = 0;
	int                  stall_left  = 0;
	int                  cyc         = 0;
	bit                  calm        = 1'b0;

	gather_copy_command_generator #(
		.MAX_OUTER(MAX_OUTER),
		.OFFSET_WIDTH(FIELD_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.gather_index(gather_index),
		.job_start(job_start),
		.empty(empty),
		.pop(pop),
		.src_offset(src_offset),
		.dst_offset(dst_offset),
		.byte_count(byte_count),
		.zero_fill(zero_fill),
		.last(last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cyc++;
		if (cyc % 300 == 0)
			calm = ($urandom_range(0, 2) == 0);
		if (stall_left != 0) begin
			stall_left--;
			pop <= 1'b0;
		end else if (calm || $urandom_range(0, 2) != 0) begin
			pop <= 1'b1;
		end else begin
			stall_left = int'($urandom_range(0, 7));
			pop <= 1'b0;
		end
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (push && !full)
				board.note_index(gather_index, job_start);
			if (pop && !empty) begin
				got.src_offset = src_offset;
				got.dst_offset = dst_offset;
				got.byte_count = byte_count;
				got.zero_fill = zero_fill;
				got.last = last;
				board.check_cmd(got);
			end
			if ((push && !full) || (pop && !empty) || cfg_write)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		board.write_reg(idx, val);
	endtask

	task automatic load_regs(logic [AXIS_W-1:0] ax, logic [SPEC_W-1:0] sp,
			logic [CNT_W-1:0] oc, logic [BYTES_W-1:0] sl, logic [STRIDE_W-1:0] sbs,
			logic [STRIDE_W-1:0] sos, logic [STRIDE_W-1:0] dos,
			logic [STRIDE_W-1:0] dbs, bit junk);
		logic [CFG_DW-1:0] hi;
		hi = junk ? {8'($urandom_range(0, 255)), $urandom} : '0;
		write_reg(REG_AXIS_DIM, {hi[CFG_DW-1:AXIS_W], ax});
		write_reg(REG_SPEC_COUNT, {hi[CFG_DW-1:SPEC_W], sp});
		write_reg(REG_OUTER_COUNT, {hi[CFG_DW-1:CNT_W], oc});
		write_reg(REG_SLICE_BYTES, {hi[CFG_DW-1:BYTES_W], sl});
		write_reg(REG_SRC_BATCH_STRIDE, sbs);
		write_reg(REG_SRC_OUTER_STRIDE, sos);
		write_reg(REG_DST_OUTER_STRIDE, dos);
		write_reg(REG_DST_BATCH_STRIDE, dbs);
		if (junk)
			write_reg(CFG_AW'(NUM_REGS + $urandom_range(0, 7)),
				{8'($urandom_range(0, 255)), $urandom});
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_item(logic [INDEX_W-1:0] gi, logic js);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(1, 8));
			if ($urandom_range(0, 3) != 0) begin
				if (push)
					push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		gather_index <= gi;
		job_start <= js;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic drain();
		if (push)
			push <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [INDEX_W-1:0] pick_index(logic [AXIS_W-1:0] ax);
		int unsigned r;
		logic [31:0] a32;
		r = $urandom_range(0, 99);
		a32 = {1'b0, ax};
		if (ax == 0 || r >= 85)
			return $urandom;
		if (r < 55)
			return $urandom_range(0, a32 - 1);
		if (r < 75)
			return 32'd0 - $urandom_range(1, a32);
		if (r < 80)
			return a32 + $urandom_range(0, 3);
		return 32'd0 - (a32 + $urandom_range(1, 3));
	endfunction

	function automatic logic [STRIDE_W-1:0] pick_stride(logic [STRIDE_W-1:0] natural);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return STRIDE_W'($urandom_range(0, 4096));
			2: return {8'($urandom_range(0, 255)), $urandom};
			3: return '1;
			default: return natural;
		endcase
	endfunction

	task automatic random_phase(int count);
		logic [AXIS_W-1:0]   ax;
		logic [SPEC_W-1:0]   sp;
		logic [CNT_W-1:0]    oc;
		logic [BYTES_W-1:0]  sl;
		logic [STRIDE_W-1:0] sbs;
		logic [STRIDE_W-1:0] sos;
		logic [STRIDE_W-1:0] dos;
		logic [STRIDE_W-1:0] dbs;
		int unsigned         r;
		r = $urandom_range(0, 99);
		if (r < 10)
			ax = AXIS_W'(1);
		else if (r < 50)
			ax = AXIS_W'($urandom_range(2, 16));
		else if (r < 75)
			ax = AXIS_W'($urandom_range(17, 1000));
		else if (r < 95)
			ax = AXIS_W'($urandom);
		else
			ax = '0;
		r = $urandom_range(0, 99);
		if (r < 45)
			sp = $urandom_range(1, 5);
		else if (r < 80)
			sp = $urandom_range(6, 40);
		else if (r < 88)
			sp = '0;
		else
			sp = $urandom;
		r = $urandom_range(0, 99);
		if (r < 70)
			oc = CNT_W'($urandom_range(1, 6));
		else if (r < 80)
			oc = CNT_W'($urandom_range(7, 20));
		else if (r < 85)
			oc = '0;
		else if (r < 92)
			oc = CNT_W'(MAX_OUTER);
		else
			oc = CNT_W'($urandom_range(MAX_OUTER + 1, 127));
		r = $urandom_range(0, 99);
		if (r < 60)
			sl = $urandom_range(1, 64);
		else if (r < 90)
			sl = $urandom;
		else
			sl = '1;
		if (sl == 0)
			sl = BYTES_W'(1);
		sos = pick_stride(STRIDE_W'(ax) * STRIDE_W'(sl));
		dos = pick_stride(STRIDE_W'(sl) * STRIDE_W'(sp));
		dbs = pick_stride(STRIDE_W'(sl) * STRIDE_W'(sp) * STRIDE_W'(oc));
		sbs = pick_stride(STRIDE_W'(ax) * STRIDE_W'(sl) * STRIDE_W'(oc));
		load_regs(ax, sp, oc, sl, sbs, sos, dos, dbs, 1'($urandom_range(0, 1)));
		for (int k = 0; k < count; k++)
			push_item(pick_index(ax), $urandom_range(0, 99) < 8);
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_item(32'd0, 1'b0);
		push_item(32'hFFFF_FFFF, 1'b0);
		push_item(32'd1, 1'b0);
		drain();

		load_regs(31'd10, 32'd3, 7'd3, 32'd16, 40'd1000, 40'd160, 40'd48, 40'd480, 1'b0);
		push_item(32'd0, 1'b0);
		push_item(32'd9, 1'b0);
		push_item(32'hFFFF_FFFF, 1'b0);
		push_item(32'hFFFF_FFF6, 1'b0);
		push_item(32'hFFFF_FFF5, 1'b1);
		push_item(32'd10, 1'b0);
		push_item(32'h7FFF_FFFF, 1'b0);
		push_item(32'h8000_0000, 1'b0);
		drain();

		load_regs('1, '1, 7'd64, '1, '1, '1, '1, '1, 1'b1);
		push_item(32'h7FFF_FFFF, 1'b0);
		push_item(32'h7FFF_FFFE, 1'b0);
		push_item(32'h8000_0000, 1'b0);
		push_item(32'h8000_0001, 1'b0);
		drain();

		load_regs(31'd0, 32'd0, 7'd0, 32'd4, 40'd7, 40'd5, 40'd3, 40'd11, 1'b1);
		push_item(32'd0, 1'b0);
		push_item(32'hFFFF_FFFF, 1'b0);
		push_item(32'd5, 1'b0);
		push_item(32'd2, 1'b1);
		drain();

		load_regs(31'd1, 32'd2, 7'd127, 32'd8, 40'd64, 40'd8, 40'd16, 40'd1024, 1'b0);
		push_item(32'd0, 1'b0);
		push_item(32'hFFFF_FFFF, 1'b0);
		push_item(32'd1, 1'b0);
		drain();

		for (int ph = 0; ph < 6; ph++)
			random_phase(26);

		if (board.failures == 0 && board.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
